// ----- src/poi_pkg.sv -----
// Package for the planar odometry integrator: widths, sequencer states,
// and the quarter-wave sine table generator. No dependencies.
package poi_pkg;

  localparam int SineTableBitsDef = 10;
  localparam logic [31:0] HalfPiQ30 = 32'd1686629713;
  localparam logic [31:0] TurnScale = 32'd683565276;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TURN1,
    ST_TURN2,
    ST_ANGLE,
    ST_FX,
    ST_FL,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_DONE,
    ST_OUT
  } state_e;

  // One table entry: Q30 Taylor series of sin, rounded to Q14.
  // Evaluated at elaboration only, to build the constant table.
  // Terms alternate in sign; divisors are (2k)(2k+1) for k = 1..7.
  function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] val;
    x = (64'(i) * 64'(HalfPiQ30)) >> bits;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = (sum > term) ? sum - term : 64'd0;
    val = (sum + 64'd32768) >> 16;
    if (val > 64'd16384) val = 64'd16384;
    return val[14:0];
  endfunction

endpackage

// ----- src/poi_mac.sv -----
// Shared signed multiplier for the integrator: one 34x34 product a request,
// registered, with an optional accumulate. Uses poi_pkg.
module poi_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               acc_i,
  input  logic               neg_i,
  input  logic signed [33:0] a_i,
  input  logic signed [33:0] b_i,
  output logic signed [67:0] acc_o
);
  import poi_pkg::*;

  logic signed [67:0] prod;
  logic signed [67:0] acc_q, acc_d;

  // Product with optional negate and accumulate.
  always_comb begin
    prod = 68'(a_i) * 68'(b_i);
    if (neg_i) prod = -prod;
    acc_d = acc_i ? acc_q + prod : prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule

// ----- src/poi_sine.sv -----
// Quarter-wave sine lookup with registered output, Q1.14.
// Uses poi_pkg::sine_entry for the constant table.
module poi_sine #(
  parameter int SineTableBits = poi_pkg::SineTableBitsDef
) (
  input  logic               clk_i,
  input  logic [15:0]        angle_i,
  output logic signed [15:0] sine_o
);
  import poi_pkg::*;

  localparam int Steps = 1 << SineTableBits;

  logic [14:0] rom [Steps+1];
  logic [1:0]  quad;
  logic [SineTableBits:0] idx;
  logic [SineTableBits-1:0] raw;
  logic signed [15:0] mag;
  logic signed [15:0] sine_q;

  for (genvar i = 0; i <= Steps; i++) begin : g_rom
    assign rom[i] = sine_entry(i, SineTableBits);
  end

  // Quadrant fold and mirror.
  always_comb begin
    quad = angle_i[15:14];
    raw = angle_i[13:14-SineTableBits];
    idx = quad[0] ? (SineTableBits+1)'(Steps) - {1'b0, raw} : {1'b0, raw};
    mag = {1'b0, rom[idx]};
  end

  always_ff @(posedge clk_i) begin
    sine_q <= quad[1] ? -mag : mag;
  end

  assign sine_o = sine_q;
endmodule

// ----- src/planar_odometry_integrator_unit.sv -----
// Planar odometry integrator: holds x, y and heading, advanced per velocity
// request by Euler or midpoint RK2. All products go through one shared 34x34
// multiplier stepped by the sequencer (turn, two velocity scalings, four trig
// products). A reset-pose request also runs the full sequencer path. The result
// sits in an output register; the next request is taken once that result is
// consumed.
// Depends on poi_pkg, poi_mac and poi_sine.
module planar_odometry_integrator_unit #(
  parameter int SineTableBits = poi_pkg::SineTableBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode_i,
  input  logic signed [15:0] vel_forward_i,
  input  logic signed [15:0] vel_lateral_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic [15:0]        time_step_i,
  input  logic signed [31:0] new_x_i,
  input  logic signed [31:0] new_y_i,
  input  logic [15:0]        new_heading_i,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pose_x_o,
  output logic signed [31:0] pose_y_o,
  output logic [15:0]        pose_heading_o,
  output logic               saturated_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);
  import poi_pkg::*;

  state_e state_q, state_d;
  logic mode_q;
  logic signed [31:0] pos_x_q, pos_y_q;
  logic [15:0] head_q;
  // latched request
  logic op_q;
  logic signed [15:0] vf_q, vl_q, w_q;
  logic [15:0] dt_q;
  logic signed [31:0] nx_q, ny_q;
  logic [15:0] nh_q;
  // intermediates
  logic [15:0] dth_q, ang_q;
  logic signed [33:0] fx_q, fl_q;
  logic signed [15:0] sin_q, cos_q;
  logic signed [67:0] dxa_q;

  logic mac_en, mac_acc, mac_neg;
  logic signed [33:0] mac_a, mac_b;
  logic signed [67:0] acc;
  logic signed [15:0] sine_s, sine_c;
  logic [15:0] ang_c;
  logic accept;

  logic signed [31:0] ox_q, oy_q;
  logic [15:0] oh_q;
  logic osat_q, ovalid_q;

  poi_mac u_mac (
    .clk_i, .rst_ni, .en_i(mac_en), .acc_i(mac_acc), .neg_i(mac_neg),
    .a_i(mac_a), .b_i(mac_b), .acc_o(acc)
  );

  poi_sine #(.SineTableBits(SineTableBits)) u_sin (
    .clk_i, .angle_i(ang_q), .sine_o(sine_s)
  );
  poi_sine #(.SineTableBits(SineTableBits)) u_cos (
    .clk_i, .angle_i(ang_c), .sine_o(sine_c)
  );
  assign ang_c = ang_q + 16'd16384;

  assign in_ready  = (state_q == ST_IDLE) && !ovalid_q;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // Round a signed value by shift, halves away from zero.
  function automatic logic signed [67:0] rnd(input logic signed [67:0] v, input int sh);
    logic [67:0] mag;
    logic [67:0] r;
    mag = v[67] ? 68'(-v) : 68'(v);
    r = (mag + (68'd1 << (sh - 1))) >> sh;
    return v[67] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] sat(input logic signed [31:0] b,
                                             input logic signed [67:0] d,
                                             output logic clip);
    logic signed [68:0] s;
    s = 69'(b) + 69'(d);
    clip = 1'b0;
    if (s > 69'sd2147483647) begin
      clip = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -69'sd2147483648) begin
      clip = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_TURN1;
      ST_TURN1: state_d = ST_TURN2;
      ST_TURN2: state_d = ST_ANGLE;
      ST_ANGLE: state_d = ST_FX;
      ST_FX:    state_d = ST_FL;
      ST_FL:    state_d = ST_P1;
      ST_P1:    state_d = ST_P2;
      ST_P2:    state_d = ST_P3;
      ST_P3:    state_d = ST_P4;
      ST_P4:    state_d = ST_DONE;
      ST_DONE:  state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mac_en = 1'b1;
    mac_acc = 1'b0;
    mac_neg = 1'b0;
    mac_a = '0;
    mac_b = '0;
    case (state_q)
      ST_TURN1: begin
        mac_a = 34'(w_q);
        mac_b = 34'($signed({1'b0, dt_q}));
      end
      ST_TURN2: begin
        // w * dt fits in 32 signed bits; take it straight from the accumulator
        mac_a = acc[33:0];
        mac_b = 34'($signed({1'b0, TurnScale}));
      end
      ST_FX: begin
        mac_a = 34'(vf_q);
        mac_b = 34'($signed({1'b0, dt_q}));
      end
      ST_FL: begin
        mac_a = 34'(vl_q);
        mac_b = 34'($signed({1'b0, dt_q}));
      end
      ST_P1: begin
        mac_a = fx_q;
        mac_b = 34'(cos_q);
      end
      ST_P2: begin
        mac_a = fl_q;
        mac_b = 34'(sin_q);
        mac_acc = 1'b1;
        mac_neg = 1'b1;
      end
      ST_P3: begin
        mac_a = fx_q;
        mac_b = 34'(sin_q);
      end
      ST_P4: begin
        mac_a = fl_q;
        mac_b = 34'(cos_q);
        mac_acc = 1'b1;
      end
      default: mac_en = 1'b0;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= opcode_i;
      vf_q <= vel_forward_i;
      vl_q <= vel_lateral_i;
      w_q  <= turn_rate_i;
      dt_q <= time_step_i;
      nx_q <= new_x_i;
      ny_q <= new_y_i;
      nh_q <= new_heading_i;
    end
    case (state_q)
      ST_ANGLE: begin
        dth_q <= 16'(rnd(acc, 44));
        ang_q <= mode_q ? head_q + 16'(rnd(acc, 45)) : head_q;
      end
      ST_FL: begin
        fx_q <= acc[33:0];
        sin_q <= sine_s;
        cos_q <= sine_c;
      end
      ST_P1: fl_q <= acc[33:0];
      ST_P3: dxa_q <= acc;
      default: ;
    endcase
  end

  // Pose, mode and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic cx, cy;
    logic signed [31:0] nxv, nyv;
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q <= 1'b0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      head_q <= '0;
      ovalid_q <= 1'b0;
      ox_q <= '0;
      oy_q <= '0;
      oh_q <= '0;
      osat_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid && cfg_ready) mode_q <= cfg_data;
      if (ovalid_q && out_ready) ovalid_q <= 1'b0;
      if (state_q == ST_OUT) begin
        ovalid_q <= 1'b1;
        if (op_q) begin
          ox_q <= pos_x_q;
          oy_q <= pos_y_q;
          oh_q <= head_q;
          osat_q <= 1'b0;
          pos_x_q <= nx_q;
          pos_y_q <= ny_q;
          head_q <= nh_q;
        end else begin
          nxv = sat(pos_x_q, rnd(dxa_q, 22), cx);
          nyv = sat(pos_y_q, rnd(acc, 22), cy);
          ox_q <= nxv;
          oy_q <= nyv;
          oh_q <= head_q + dth_q;
          osat_q <= cx | cy;
          pos_x_q <= nxv;
          pos_y_q <= nyv;
          head_q <= head_q + dth_q;
        end
      end
    end
  end

  assign out_valid      = ovalid_q;
  assign pose_x_o       = ox_q;
  assign pose_y_o       = oy_q;
  assign pose_heading_o = oh_q;
  assign saturated_o    = osat_q;

  // A request is taken only with the sequencer idle and the output empty.
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_TURN1) else $error("accept did not start sequence");
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> out_valid) else $error("result not presented");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> !in_ready) else $error("accepted while result held");
endmodule
